@@ hw/rtl/string_key_merge_sorter_top_defines.svh @@
// Assertion macros used by the string key merge sorter datapath.
`ifndef STRING_KEY_MERGE_SORTER_TOP_DEFINES_SVH
`define STRING_KEY_MERGE_SORTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKMS_ASSERT_HOLD(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/skms_pkg.sv @@
// Package with shared types and constants of the string key merge sorter.
package skms_pkg;

  localparam int KEY_BITS      = 40;
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_CHARS_DEF = 5;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE_INIT,
    ST_MERGE,
    ST_EMIT_INIT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic in_open;
    logic store;
    logic sort_begin;
    logic merge_init;
    logic merge_step;
    logic emit_init;
    logic emit_step;
    logic run_clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_full;
    logic out_ready;
    logic sorted;
    logic merge_last;
    logic emit_more;
  } stat_t;

endpackage

@@ hw/rtl/skms_if.sv @@
// Channel interfaces for key input and sorted key output.
interface skms_in_if;
  logic               valid;
  logic               ready;
  skms_pkg::key_t     key_bytes;
  logic               last_key;

  modport source (output valid, output key_bytes, output last_key, input ready);
  modport sink   (input valid, input key_bytes, input last_key, output ready);
endinterface

interface skms_out_if;
  logic               valid;
  logic               ready;
  skms_pkg::key_t     sorted_key;
  logic               run_end;
  logic               overflowed;

  modport source (output valid, output sorted_key, output run_end, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_key, input run_end, input overflowed,
                  output ready);
endinterface

@@ hw/rtl/string_key_merge_sorter_top.sv @@
// Top level of the string key merge sorter.
//
//   Channel    Role    Payload
//   keys_in    sink    key_bytes[39:0], last_key
//   keys_out   source  sorted_key[39:0], run_end, overflowed
//
// Keys load into the key store while the sorter is in its load state.
// The transfer marked last_key starts a bottom-up merge sort of N stored keys:
// ceil(log2 N) passes through the two-read-port stores, each merge going through
// a setup state, an init state and one merge step per key.
// Output then runs at one key per cycle, set by the store read port and the
// output register; a stall on keys_out holds the sequencer.
// Reset is synchronous; it empties the run and clears the output valid flag.
module string_key_merge_sorter_top #(
  parameter int CAPACITY  = skms_pkg::CAPACITY_DEF,
  parameter int KEY_CHARS = skms_pkg::KEY_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  skms_in_if.sink     keys_in,
  skms_out_if.source  keys_out
);
  import skms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  skms_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  skms_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_CHARS (KEY_CHARS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .keys_in  (keys_in),
    .keys_out (keys_out),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ hw/rtl/skms_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module skms_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/skms_ctrl.sv @@
// Controller state machine that sequences loading, merge passes and output.
module skms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  skms_pkg::stat_t stat,
  output skms_pkg::cmd_t  cmd
);
  import skms_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        cmd.in_open = 1'b1;
        if (stat.in_valid) begin
          cmd.store = 1'b1;
          if (stat.in_last) begin
            cmd.sort_begin = 1'b1;
            state_next     = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        state_next = stat.sorted ? ST_EMIT_INIT : ST_MERGE_INIT;
      end
      ST_MERGE_INIT: begin
        cmd.merge_init = 1'b1;
        state_next     = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
        if (stat.merge_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.emit_more) begin
          cmd.emit_step = !stat.out_full || stat.out_ready;
        end else begin
          cmd.run_clear = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/skms_dpath.sv @@
// Datapath with key stores, merge pointers and the output register.
`include "string_key_merge_sorter_top_defines.svh"

module skms_dpath #(
  parameter int CAPACITY  = skms_pkg::CAPACITY_DEF,
  parameter int KEY_CHARS = skms_pkg::KEY_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  skms_in_if.sink         keys_in,
  skms_out_if.source      keys_out,
  input  skms_pkg::cmd_t  cmd,
  output skms_pkg::stat_t stat
);
  import skms_pkg::*;

  localparam int KEY_W = (8 * KEY_CHARS < KEY_BITS) ? 8 * KEY_CHARS : KEY_BITS;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]    count;
  logic             dropped;
  logic             src_sel;
  logic [CW:0]      width;
  logic [CW-1:0]    base;
  logic [CW-1:0]    ptr_a, ptr_a_next, lim_a;
  logic [CW-1:0]    ptr_b, ptr_b_next, lim_b;
  logic [CW-1:0]    wr;
  logic [CW+1:0]    sum_a, sum_b;
  logic [CW-1:0]    lim_a_val, lim_b_val;
  logic             store_ok;
  logic             a_ok, b_ok, take_a;
  logic [KEY_W-1:0] r0a, r0b, r1a, r1b;
  logic [KEY_W-1:0] head_a, head_b, merge_min;
  logic             we0, we1;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic             out_valid;
  logic [KEY_W-1:0] out_key;
  logic             out_run_end;
  logic             out_ovf;

  assign store_ok  = cmd.store && (count < CAP_C);
  assign sum_a     = (CW+2)'(base) + (CW+2)'(width);
  assign sum_b     = (CW+2)'(base) + ((CW+2)'(width) << 1);
  assign lim_a_val = (sum_a < (CW+2)'(count)) ? sum_a[CW-1:0] : count;
  assign lim_b_val = (sum_b < (CW+2)'(count)) ? sum_b[CW-1:0] : count;

  assign head_a    = src_sel ? r1a : r0a;
  assign head_b    = src_sel ? r1b : r0b;
  assign a_ok      = ptr_a < lim_a;
  assign b_ok      = ptr_b < lim_b;
  assign take_a    = a_ok && (!b_ok || (head_a < head_b));
  assign merge_min = take_a ? head_a : head_b;

  always_comb begin
    ptr_a_next = ptr_a;
    ptr_b_next = ptr_b;
    if (cmd.merge_init) begin
      ptr_a_next = base;
      ptr_b_next = lim_a_val;
    end else if (cmd.merge_step) begin
      if (take_a) begin
        ptr_a_next = ptr_a + CW'(1);
      end else begin
        ptr_b_next = ptr_b + CW'(1);
      end
    end else if (cmd.emit_init) begin
      ptr_a_next = '0;
    end else if (cmd.emit_step) begin
      ptr_a_next = ptr_a + CW'(1);
    end
  end

  // Keys load into store zero; each pass merges from one store into the other.
  assign we0   = store_ok || (cmd.merge_step && src_sel);
  assign we1   = cmd.merge_step && !src_sel;
  assign waddr = cmd.store ? count[AW-1:0] : wr[AW-1:0];
  assign wdata = cmd.store ? keys_in.key_bytes[KEY_W-1:0] : merge_min;

  skms_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ptr_a_next[AW-1:0]),
    .rdata_a (r0a),
    .raddr_b (ptr_b_next[AW-1:0]),
    .rdata_b (r0b)
  );

  skms_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ptr_a_next[AW-1:0]),
    .rdata_a (r1a),
    .raddr_b (ptr_b_next[AW-1:0]),
    .rdata_b (r1b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      src_sel   <= 1'b0;
      width     <= '0;
      base      <= '0;
      ptr_a     <= '0;
      ptr_b     <= '0;
      lim_a     <= '0;
      lim_b     <= '0;
      wr        <= '0;
      out_valid <= 1'b0;
    end else begin
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
      if (store_ok) begin
        count <= count + CW'(1);
      end else if (cmd.store) begin
        dropped <= 1'b1;
      end
      if (cmd.run_clear) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.sort_begin) begin
        width   <= (CW+1)'(1);
        base    <= '0;
        src_sel <= 1'b0;
      end
      if (cmd.merge_init) begin
        lim_a <= lim_a_val;
        lim_b <= lim_b_val;
        wr    <= base;
      end
      if (cmd.merge_step) begin
        wr <= wr + CW'(1);
        if (stat.merge_last) begin
          if (lim_b == count) begin
            base    <= '0;
            width   <= width << 1;
            src_sel <= !src_sel;
          end else begin
            base <= lim_b;
          end
        end
      end
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (keys_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_key     <= head_a;
      out_run_end <= (ptr_a + CW'(1)) == count;
      out_ovf     <= dropped;
    end
  end

  assign keys_in.ready       = cmd.in_open;
  assign keys_out.valid      = out_valid;
  assign keys_out.sorted_key = KEY_BITS'(out_key);
  assign keys_out.run_end    = out_run_end;
  assign keys_out.overflowed = out_ovf;

  assign stat.in_valid   = keys_in.valid;
  assign stat.in_last    = keys_in.last_key;
  assign stat.out_full   = out_valid;
  assign stat.out_ready  = keys_out.ready;
  assign stat.sorted     = width >= (CW+1)'(count);
  assign stat.merge_last = (wr + CW'(1)) == lim_b;
  assign stat.emit_more  = ptr_a < count;

  `SKMS_ASSERT_HOLD(a_merge_live, cmd.merge_step, a_ok || b_ok, "merge step with both runs empty")
  `SKMS_ASSERT_HOLD(a_merge_bounds, cmd.merge_step, (ptr_a <= lim_a) && (ptr_b <= lim_b) && (wr < lim_b), "merge pointer out of range")
  `SKMS_ASSERT_NEXT(a_drop_flag, cmd.store && (count == CAP_C), dropped, "full store did not flag a drop")
  `SKMS_ASSERT_HOLD(a_emit_room, cmd.emit_step, !out_valid || keys_out.ready, "output register overwritten")
  `SKMS_ASSERT_NEXT(a_emit_loads, cmd.emit_step, out_valid, "emitted key not presented")

endmodule
